// ===== sv/dwc_pkg.sv =====
// Shared types, constants and arithmetic helpers for the DFA word counter.
package dwc_pkg;

	localparam int unsigned MAX_STATES_DEF = 64;
	localparam int unsigned ALPHABET_DEF   = 26;
	localparam int unsigned CNT_W          = 30;

	localparam logic [CNT_W-1:0] WORD_MOD = 30'd1000000007;

	// Input item function codes.
	localparam logic [1:0] FUNC_SET_EDGE = 2'd0;
	localparam logic [1:0] FUNC_MARK     = 2'd1;
	localparam logic [1:0] FUNC_COUNT    = 2'd2;
	localparam logic [1:0] FUNC_CLEAR    = 2'd3;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic tbl_wr;        // write the transition carried by the input transfer
		logic clr_wr;        // clearing sweep: write a dead entry and step the address
		logic flags_clr;     // drop every accepting mark
		logic flag_set;      // mark the input source state accepting
		logic reach_init;    // seed the reachability sets
		logic reach_apply;   // fold the edge just read into the reachability sets
		logic round_restart; // start a new reachability round
		logic adv;           // step to the next letter, wrapping into the next state
		logic skip;          // step to the next state
		logic dp_init;       // seed the path count rounds
		logic rd_cur;        // read the current round's count of the present state
		logic cap_cur;       // hold that count
		logic rd_nxt;        // read the next round's count of the edge target
		logic dp_acc;        // add the held count into the edge target, and into the total if it accepts
		logic dp_round;      // swap count banks at the end of a round
		logic out_load;      // load the result register
	} dwc_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clr_last;
		logic s_last;
		logic l_last;
		logic changed;
		logic state_live;
		logic tgt_useful;
		logic rounds_last;
		logic nxt_empty;
	} dwc_status_t;

	// Addition modulo WORD_MOD of two values already below it.
	function automatic logic [CNT_W-1:0] mod_add(input logic [CNT_W-1:0] a,
		input logic [CNT_W-1:0] b);
		logic [CNT_W:0] sum;
		sum = {1'b0, a} + {1'b0, b};
		if (sum >= {1'b0, WORD_MOD}) begin
			sum = sum - {1'b0, WORD_MOD};
		end
		return sum[CNT_W-1:0];
	endfunction

endpackage

// ===== sv/dfa_word_counter_unit.sv =====
// Top level of the DFA word counter: controller plus datapath.
// Loads a deterministic automaton one transfer at a time and, on a count
// request, returns the number of accepted words modulo 1000000007 or flags an
// infinite language. Edge loads and accepting marks may follow back to back.
// A clear, and every reset, runs a sweep over all MAX_STATES *
// 2**clog2(ALPHABET) entries of the transition memory (2048 by default)
// during which no transfer is accepted. A count is bound by the single read
// port of the transition memory: each reachability round reads every edge
// of the configured states in turn, and rounds repeat until the sets settle
// (at most num_states rounds). Up to num_states + 1 counting rounds follow,
// each skipping every state outside the walk, reading the count of every
// live state and then its edges letter by letter, and closing with a bank
// swap; counting stops early once no walk survives. A finished result waits
// in an output register while new transfers are taken.
module dfa_word_counter_unit import dwc_pkg::*; #(
	parameter int unsigned MAX_STATES = MAX_STATES_DEF,
	parameter int unsigned ALPHABET   = ALPHABET_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic [6:0]       num_states,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [1:0]       func,
	input  logic [5:0]       source_state,
	input  logic [5:0]       target_state,
	input  logic [4:0]       letter,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [CNT_W-1:0] word_count,
	output logic             infinite
);

	dwc_cmd_t    cmd;
	dwc_status_t status;

	dwc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.func      (func),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	dwc_datapath #(
		.MAX_STATES (MAX_STATES),
		.ALPHABET   (ALPHABET)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.cfg_wr_en    (cfg_wr_en),
		.num_states   (num_states),
		.source_state (source_state),
		.target_state (target_state),
		.letter       (letter),
		.word_count   (word_count),
		.infinite     (infinite)
	);

endmodule

// ===== sv/dwc_datapath.sv =====
// Datapath of the DFA word counter: transition memory, state sets, path counts.
module dwc_datapath import dwc_pkg::*; #(
	parameter int unsigned MAX_STATES = MAX_STATES_DEF,
	parameter int unsigned ALPHABET   = ALPHABET_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  dwc_cmd_t         cmd,
	output dwc_status_t      status,
	input  logic             cfg_wr_en,
	input  logic [6:0]       num_states,
	input  logic [5:0]       source_state,
	input  logic [5:0]       target_state,
	input  logic [4:0]       letter,
	output logic [CNT_W-1:0] word_count,
	output logic             infinite
);

	localparam int unsigned SW     = $clog2(MAX_STATES);
	localparam int unsigned LW     = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
	localparam int unsigned NW     = $clog2(MAX_STATES + 1);
	localparam int unsigned AW     = SW + LW;
	localparam int unsigned TDEPTH = 2 ** AW;
	localparam int unsigned CDEPTH = 2 ** (SW + 1);

	logic [NW-1:0]         num_q;
	logic [NW-1:0]         num_sat;
	logic [SW-1:0]         s_q;
	logic [LW-1:0]         l_q;
	logic [NW-1:0]         r_q;
	logic [AW-1:0]         clr_q;
	logic [MAX_STATES-1:0] acc_q;
	logic [MAX_STATES-1:0] fwd_q;
	logic [MAX_STATES-1:0] bwd_q;
	logic [MAX_STATES-1:0] alive_cur_q;
	logic [MAX_STATES-1:0] alive_nxt_q;
	logic [MAX_STATES-1:0] in_use;
	logic                  changed_q;
	logic                  bank_q;
	logic                  inf_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [CNT_W-1:0]      total_q;
	logic [SW-1:0]         t_q;

	logic [NW-1:0]         tbl_mem [TDEPTH];
	logic [NW-1:0]         tbl_rd_q;
	logic                  tbl_we;
	logic [AW-1:0]         tbl_wa;
	logic [NW-1:0]         tbl_wd;

	logic [CNT_W-1:0]      cnt_mem [CDEPTH];
	logic [CNT_W-1:0]      cnt_rd_q;
	logic                  cnt_we;
	logic [SW:0]           cnt_wa;
	logic [CNT_W-1:0]      cnt_wd;
	logic [SW:0]           cnt_ra;

	logic                  src_ok;
	logic                  let_ok;
	logic                  dst_ok;
	logic                  t_live;
	logic [SW-1:0]         t_idx;
	logic                  cur_change;
	logic [CNT_W-1:0]      old_cnt;

	// Register write, saturated into the supported range.
	always_comb begin
		if (num_states == 7'd0) begin
			num_sat = NW'(1);
		end else if (32'(num_states) > MAX_STATES) begin
			num_sat = NW'(MAX_STATES);
		end else begin
			num_sat = NW'(num_states);
		end
	end

	// States below the configured count.
	always_comb begin
		for (int i = 0; i < MAX_STATES; i++) begin
			in_use[i] = (i < int'(num_q));
		end
	end

	// Decode of the transfer fields and of the edge just read.
	assign src_ok  = 32'(source_state) < MAX_STATES;
	assign let_ok  = 32'(letter) < ALPHABET;
	assign dst_ok  = 32'(target_state) < MAX_STATES;
	assign t_live  = tbl_rd_q < num_q;
	assign t_idx   = tbl_rd_q[SW-1:0];
	assign old_cnt = alive_nxt_q[t_q] ? cnt_rd_q : '0;

	assign cur_change = t_live && ((fwd_q[s_q] && !fwd_q[t_idx]) ||
		(bwd_q[t_idx] && !bwd_q[s_q]));

	assign status.clr_last    = &clr_q;
	assign status.s_last      = (NW'(s_q) + NW'(1)) == num_q;
	assign status.l_last      = l_q == LW'(ALPHABET - 1);
	assign status.changed     = changed_q | cur_change;
	assign status.state_live  = fwd_q[s_q] && bwd_q[s_q] && alive_cur_q[s_q];
	assign status.tgt_useful  = t_live && fwd_q[t_idx] && bwd_q[t_idx];
	assign status.rounds_last = r_q == num_q;
	assign status.nxt_empty   = alive_nxt_q == '0;

	// Transition memory write port: clearing sweep or a loaded edge.
	always_comb begin
		tbl_we = 1'b0;
		tbl_wa = {SW'(source_state), LW'(letter)};
		tbl_wd = dst_ok ? NW'(target_state) : NW'(MAX_STATES);
		if (cmd.clr_wr) begin
			tbl_we = 1'b1;
			tbl_wa = clr_q;
			tbl_wd = NW'(MAX_STATES);
		end else if (cmd.tbl_wr && src_ok && let_ok) begin
			tbl_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (tbl_we) begin
			tbl_mem[tbl_wa] <= tbl_wd;
		end
		tbl_rd_q <= tbl_mem[{s_q, l_q}];
	end

	// Path count memory, two banks selected by the round parity.
	always_comb begin
		cnt_ra = cmd.rd_cur ? {bank_q, s_q} : {~bank_q, t_idx};
		cnt_we = cmd.dp_init | cmd.dp_acc;
		cnt_wa = cmd.dp_init ? '0 : {~bank_q, t_q};
		cnt_wd = cmd.dp_init ? CNT_W'(1) : mod_add(old_cnt, cnt_q);
	end

	always_ff @(posedge clk) begin
		if (cnt_we) begin
			cnt_mem[cnt_wa] <= cnt_wd;
		end
		cnt_rd_q <= cnt_mem[cnt_ra];
	end

	// Configuration, walk counters and the clearing address.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_q <= NW'(1);
			s_q   <= '0;
			l_q   <= '0;
			clr_q <= '0;
		end else begin
			if (cfg_wr_en) begin
				num_q <= num_sat;
			end
			if (cmd.clr_wr) begin
				clr_q <= clr_q + AW'(1);
			end
			if (cmd.dp_init || cmd.round_restart || cmd.reach_init || cmd.dp_round) begin
				s_q <= '0;
				l_q <= '0;
			end else if (cmd.adv) begin
				if (status.l_last) begin
					l_q <= '0;
					s_q <= s_q + SW'(1);
				end else begin
					l_q <= l_q + LW'(1);
				end
			end else if (cmd.skip) begin
				l_q <= '0;
				s_q <= s_q + SW'(1);
			end
		end
	end

	// Accepting marks and the forward and backward reachability sets.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q     <= '0;
			fwd_q     <= '0;
			bwd_q     <= '0;
			changed_q <= 1'b0;
		end else begin
			if (cmd.flags_clr) begin
				acc_q <= '0;
			end else if (cmd.flag_set && src_ok) begin
				acc_q[SW'(source_state)] <= 1'b1;
			end
			if (cmd.reach_init) begin
				fwd_q     <= MAX_STATES'(1);
				bwd_q     <= acc_q & in_use;
				changed_q <= 1'b0;
			end else begin
				if (cmd.reach_apply && t_live) begin
					if (fwd_q[s_q]) begin
						fwd_q[t_idx] <= 1'b1;
					end
					if (bwd_q[t_idx]) begin
						bwd_q[s_q] <= 1'b1;
					end
				end
				if (cmd.round_restart) begin
					changed_q <= 1'b0;
				end else if (cmd.reach_apply) begin
					changed_q <= changed_q | cur_change;
				end
			end
		end
	end

	// Per-length rounds: live walk sets, bank parity, round count and total.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alive_cur_q <= '0;
			alive_nxt_q <= '0;
			bank_q      <= 1'b0;
			r_q         <= '0;
			inf_q       <= 1'b0;
			total_q     <= '0;
		end else begin
			if (cmd.dp_init) begin
				alive_cur_q <= MAX_STATES'(1);
				alive_nxt_q <= '0;
				bank_q      <= 1'b0;
				r_q         <= '0;
				total_q     <= acc_q[0] ? CNT_W'(1) : '0;
			end else if (cmd.dp_round) begin
				alive_cur_q <= alive_nxt_q;
				alive_nxt_q <= '0;
				bank_q      <= ~bank_q;
				r_q         <= r_q + NW'(1);
				inf_q       <= |alive_nxt_q;
			end else if (cmd.dp_acc) begin
				alive_nxt_q[t_q] <= 1'b1;
				if (acc_q[t_q]) begin
					total_q <= mod_add(total_q, cnt_q);
				end
			end
		end
	end

	// Held operands of the count update and the result register.
	always_ff @(posedge clk) begin
		if (cmd.cap_cur) begin
			cnt_q <= cnt_rd_q;
		end
		if (cmd.rd_nxt) begin
			t_q <= t_idx;
		end
		if (cmd.out_load) begin
			word_count <= inf_q ? '0 : total_q;
			infinite   <= inf_q;
		end
	end

endmodule

// ===== sv/dwc_ctrl.sv =====
// Controller state machine of the DFA word counter.
module dwc_ctrl import dwc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  func,
	output logic        out_valid,
	input  logic        out_stall,
	input  dwc_status_t status,
	output dwc_cmd_t    cmd
);

	localparam logic [3:0] S_CLEAR   = 4'd0;
	localparam logic [3:0] S_IDLE    = 4'd1;
	localparam logic [3:0] S_R_ADDR  = 4'd2;
	localparam logic [3:0] S_R_DATA  = 4'd3;
	localparam logic [3:0] S_D_INIT  = 4'd4;
	localparam logic [3:0] S_D_STATE = 4'd5;
	localparam logic [3:0] S_D_CUR   = 4'd6;
	localparam logic [3:0] S_D_ADDR  = 4'd7;
	localparam logic [3:0] S_D_TGT   = 4'd8;
	localparam logic [3:0] S_D_ACC   = 4'd9;
	localparam logic [3:0] S_D_ROUND = 4'd10;
	localparam logic [3:0] S_DONE    = 4'd11;

	logic [3:0] state_q;
	logic [3:0] state_nxt;
	logic       out_valid_q;
	logic       in_xfer;
	logic       edge_end;

	assign in_stall  = state_q != S_IDLE;
	assign in_xfer   = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign edge_end  = status.s_last && status.l_last;

	// Next state and command decode.
	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (status.clr_last) begin
					state_nxt = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_xfer) begin
					unique case (func)
						FUNC_SET_EDGE: cmd.tbl_wr = 1'b1;
						FUNC_MARK:     cmd.flag_set = 1'b1;
						FUNC_COUNT: begin
							cmd.reach_init = 1'b1;
							state_nxt      = S_R_ADDR;
						end
						FUNC_CLEAR: begin
							cmd.flags_clr = 1'b1;
							state_nxt     = S_CLEAR;
						end
						default: ;
					endcase
				end
			end
			S_R_ADDR: state_nxt = S_R_DATA;
			S_R_DATA: begin
				cmd.reach_apply = 1'b1;
				cmd.adv         = 1'b1;
				state_nxt       = S_R_ADDR;
				if (edge_end) begin
					if (status.changed) begin
						cmd.round_restart = 1'b1;
					end else begin
						state_nxt = S_D_INIT;
					end
				end
			end
			S_D_INIT: begin
				cmd.dp_init = 1'b1;
				state_nxt   = S_D_STATE;
			end
			S_D_STATE: begin
				if (status.state_live) begin
					cmd.rd_cur = 1'b1;
					state_nxt  = S_D_CUR;
				end else if (status.s_last) begin
					state_nxt = S_D_ROUND;
				end else begin
					cmd.skip = 1'b1;
				end
			end
			S_D_CUR: begin
				cmd.cap_cur = 1'b1;
				state_nxt   = S_D_ADDR;
			end
			S_D_ADDR: state_nxt = S_D_TGT;
			S_D_TGT, S_D_ACC: begin
				if (state_q == S_D_TGT && status.tgt_useful) begin
					cmd.rd_nxt = 1'b1;
					state_nxt  = S_D_ACC;
				end else begin
					cmd.dp_acc = state_q == S_D_ACC;
					cmd.adv    = 1'b1;
					if (edge_end) begin
						state_nxt = S_D_ROUND;
					end else if (status.l_last) begin
						state_nxt = S_D_STATE;
					end else begin
						state_nxt = S_D_ADDR;
					end
				end
			end
			S_D_ROUND: begin
				cmd.dp_round = 1'b1;
				if (status.rounds_last || status.nxt_empty) begin
					state_nxt = S_DONE;
				end else begin
					state_nxt = S_D_STATE;
				end
			end
			S_DONE: begin
				if (!(out_valid_q && out_stall)) begin
					cmd.out_load = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: state_nxt = S_CLEAR;
		endcase
	end

	// State register and result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== sv/dwc_checker.sv =====
// Port-level checks of the DFA word counter and their binding to the top level.
module dwc_checker import dwc_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_stall,
	input logic [1:0]       func,
	input logic             out_valid,
	input logic             out_stall,
	input logic [CNT_W-1:0] word_count,
	input logic             infinite
);

	// A stalled result holds until its transfer.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(word_count) && $stable(infinite))
		else $error("result changed while stalled");

	// An infinite language reports a zero count.
	a_inf_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && infinite |-> word_count == '0)
		else $error("infinite result with non-zero count");

	// Counts are reduced below the modulus.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> word_count < WORD_MOD)
		else $error("count not reduced");

	// A count request keeps the input side busy on the next cycle.
	a_count_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && func == FUNC_COUNT |=> in_stall)
		else $error("input taken straight after a count request");

endmodule

bind dfa_word_counter_unit dwc_checker u_dwc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.func       (func),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.word_count (word_count),
	.infinite   (infinite)
);

// ===== dv/tb_top.sv =====
// Self-checking testbench for the DFA word counter with a predicting scoreboard.
`timescale 1ns / 100ps

module tb_top;
	import dwc_pkg::*;

	localparam int unsigned N_MAX = 64;
	localparam int unsigned N_LET = 26;
	localparam int unsigned DEAD  = N_MAX;
	localparam longint MOD_VAL    = 1000000007;

	typedef struct {
		logic [CNT_W-1:0] words;
		logic             inf;
	} word_result_t;

	// Scoreboard: keeps its own copy of the automaton and predicts each count.
	class word_count_board;
		logic [6:0]   edge_tbl[N_MAX*N_LET];
		bit           accept_mark[N_MAX];
		int unsigned  states_used;
		word_result_t pending_q[$];
		int           errors;
		int           results_seen;
		int           infinite_seen;

		function new();
			for (int i = 0; i < N_MAX*N_LET; i++) edge_tbl[i] = 7'(DEAD);
			for (int i = 0; i < N_MAX; i++) accept_mark[i] = 0;
			states_used = 1;
			errors = 0;
			results_seen = 0;
			infinite_seen = 0;
		endfunction

		function void set_states(logic [6:0] v);
			if (v < 1) states_used = 1;
			else if (v > N_MAX) states_used = N_MAX;
			else states_used = 32'(v);
		endfunction

		function int unsigned follow(int unsigned s, int unsigned l);
			int unsigned t;
			t = 32'(edge_tbl[s*N_LET + l]);
			return (t < states_used) ? t : DEAD;
		endfunction

		// Works out the word count of the loaded automaton.
		function word_result_t predict_count();
			word_result_t r;
			bit fwd[N_MAX+1];
			bit bwd[N_MAX+1];
			bit live[N_MAX+1];
			int indeg[N_MAX];
			int work_q[$];
			longint cur[N_MAX];
			longint nxt[N_MAX];
			longint total;
			bit changed;
			int n_live, n_gone, s, t;
			for (int i = 0; i <= N_MAX; i++) begin
				fwd[i] = 0;
				bwd[i] = 0;
				live[i] = 0;
			end
			fwd[0] = 1;
			for (int i = 0; i < states_used; i++) bwd[i] = accept_mark[i];
			// Reachability from the start and towards an accepting state.
			changed = 1;
			while (changed) begin
				changed = 0;
				for (int i = 0; i < states_used; i++) begin
					for (int l = 0; l < N_LET; l++) begin
						t = follow(i, l);
						if (t == DEAD) continue;
						if (fwd[i] && !fwd[t]) begin
							fwd[t] = 1;
							changed = 1;
						end
						if (bwd[t] && !bwd[i]) begin
							bwd[i] = 1;
							changed = 1;
						end
					end
				end
			end
			r.words = '0;
			r.inf = 0;
			if (!bwd[0]) return r;
			n_live = 0;
			for (int i = 0; i < states_used; i++) begin
				live[i] = fwd[i] && bwd[i];
				if (live[i]) n_live++;
				indeg[i] = 0;
			end
			// A cycle among useful states is found by peeling off sources.
			for (int i = 0; i < states_used; i++) begin
				if (!live[i]) continue;
				for (int l = 0; l < N_LET; l++) begin
					t = follow(i, l);
					if (live[t]) indeg[t]++;
				end
			end
			for (int i = 0; i < states_used; i++)
				if (live[i] && indeg[i] == 0) work_q = {work_q, i};
			n_gone = 0;
			while (work_q.size() > 0) begin
				s = work_q.pop_front();
				n_gone++;
				for (int l = 0; l < N_LET; l++) begin
					t = follow(s, l);
					if (live[t]) begin
						indeg[t]--;
						if (indeg[t] == 0) work_q = {work_q, t};
					end
				end
			end
			if (n_gone < n_live) begin
				r.inf = 1;
				return r;
			end
			// Words counted length by length.
			for (int i = 0; i < N_MAX; i++) cur[i] = 0;
			cur[0] = 1;
			total = accept_mark[0] ? 1 : 0;
			for (int rnd = 0; rnd <= states_used; rnd++) begin
				for (int i = 0; i < N_MAX; i++) nxt[i] = 0;
				for (int i = 0; i < states_used; i++) begin
					if (!live[i] || cur[i] == 0) continue;
					for (int l = 0; l < N_LET; l++) begin
						t = follow(i, l);
						if (!live[t]) continue;
						nxt[t] = (nxt[t] + cur[i]) % MOD_VAL;
						if (accept_mark[t]) total = (total + cur[i]) % MOD_VAL;
					end
				end
				cur = nxt;
			end
			r.words = total[CNT_W-1:0];
			return r;
		endfunction

		function void note_input(logic [1:0] f, logic [5:0] src, logic [5:0] dst,
			logic [4:0] let_code);
			case (f)
				FUNC_SET_EDGE: begin
					if (let_code < N_LET) edge_tbl[src*N_LET + let_code] = {1'b0, dst};
				end
				FUNC_MARK: begin
					accept_mark[src] = 1;
				end
				FUNC_CLEAR: begin
					for (int i = 0; i < N_MAX*N_LET; i++) edge_tbl[i] = 7'(DEAD);
					for (int i = 0; i < N_MAX; i++) accept_mark[i] = 0;
				end
				default: begin
					pending_q = {pending_q, predict_count()};
				end
			endcase
		endfunction

		function void check_result(logic [CNT_W-1:0] words, logic inf);
			word_result_t e;
			results_seen++;
			if (inf) infinite_seen++;
			if (pending_q.size() == 0) begin
				$display("%0t: unexpected result word_count=%0d infinite=%0b",
					$time, words, inf);
				errors++;
				return;
			end
			e = pending_q.pop_front();
			if (words !== e.words) begin
				$display("%0t: word_count mismatch: expected %0d, actual %0d",
					$time, e.words, words);
				errors++;
			end
			if (inf !== e.inf) begin
				$display("%0t: infinite mismatch: expected %0b, actual %0b",
					$time, e.inf, inf);
				errors++;
			end
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             cfg_wr_en;
	logic [6:0]       num_states;
	logic             in_valid;
	logic             in_stall;
	logic [1:0]       func;
	logic [5:0]       source_state;
	logic [5:0]       target_state;
	logic [4:0]       letter;
	logic             out_valid;
	logic             out_stall;
	logic [CNT_W-1:0] word_count;
	logic             infinite;

	word_count_board board;
	int send_idle_pct;
	int recv_idle_pct;
	int recv_hold;
	int unsigned cur_states;

	dfa_word_counter_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.num_states   (num_states),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.func         (func),
		.source_state (source_state),
		.target_state (target_state),
		.letter       (letter),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.word_count   (word_count),
		.infinite     (infinite)
	);

	// Clock with a 12 ns period.
	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// Receiver: random stalls, or one long hold-off counted in cycles.
	always @(negedge clk) begin
		if (recv_hold > 0) begin
			out_stall = 1'b1;
			recv_hold = recv_hold - 1;
		end else begin
			out_stall = ($urandom_range(99) < recv_idle_pct);
		end
	end

	// Every result transfer is checked at the rising edge.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			board.check_result(word_count, infinite);
		end
	end

	// Ends the run if it hangs.
	initial begin
		#48000000;
		$display("dfa_word_counter_unit regression: fail");
		$finish;
	end

	// Offers one item and waits until the block takes it.
	task automatic send_item(logic [1:0] f, logic [5:0] src, logic [5:0] dst,
		logic [4:0] let_code);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		func = f;
		source_state = src;
		target_state = dst;
		letter = let_code;
		in_valid = 1'b1;
		forever begin
			@(posedge clk);
			if (!in_stall) break;
		end
		board.note_input(f, src, dst, let_code);
	endtask

	// Lets every expected result arrive, then covers a clearing sweep.
	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (board.pending_q.size() > 0) @(posedge clk);
		repeat (2200) @(posedge clk);
	endtask

	task automatic write_states(logic [6:0] v);
		drain();
		@(negedge clk);
		cfg_wr_en = 1'b1;
		num_states = v;
		@(negedge clk);
		cfg_wr_en = 1'b0;
		board.set_states(v);
		cur_states = board.states_used;
	endtask

	// One random load sequence ending in a count, with some noise mixed in.
	task automatic random_group();
		int k, pick;
		int unsigned top;
		top = cur_states - 1;
		if ($urandom_range(2) == 0)
			send_item(FUNC_CLEAR, 6'($urandom), 6'($urandom), 5'($urandom));
		k = $urandom_range(1, 4);
		for (int i = 0; i < k; i++) begin
			pick = $urandom_range(99);
			if (pick < 65)
				send_item(FUNC_SET_EDGE, 6'($urandom_range(top)), 6'($urandom_range(top)),
					5'($urandom_range(N_LET-1)));
			else if (pick < 78)
				send_item(FUNC_SET_EDGE, 6'($urandom), 6'($urandom), 5'($urandom));
			else if (pick < 95)
				send_item(FUNC_MARK, 6'($urandom_range(top)), 6'($urandom), 5'($urandom));
			else
				send_item(FUNC_MARK, 6'($urandom), 6'($urandom), 5'($urandom));
		end
		send_item(FUNC_COUNT, 6'($urandom), 6'($urandom), 5'($urandom));
	endtask

	initial begin
		board = new();
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		num_states = 7'd1;
		in_valid = 1'b0;
		func = FUNC_SET_EDGE;
		source_state = '0;
		target_state = '0;
		letter = '0;
		out_stall = 1'b0;
		send_idle_pct = 14;
		recv_idle_pct = 63;
		recv_hold = 0;
		cur_states = 1;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: empty automaton, empty word, self loop, ignored letter.
		send_item(FUNC_COUNT, 6'd0, 6'd0, 5'd0);
		send_item(FUNC_MARK, 6'd0, 6'd0, 5'd0);
		send_item(FUNC_COUNT, 6'd0, 6'd0, 5'd0);
		send_item(FUNC_SET_EDGE, 6'd0, 6'd0, 5'd25);
		send_item(FUNC_COUNT, 6'd0, 6'd0, 5'd0);
		send_item(FUNC_CLEAR, 6'd63, 6'd63, 5'd31);
		send_item(FUNC_MARK, 6'd0, 6'd0, 5'd0);
		send_item(FUNC_SET_EDGE, 6'd0, 6'd0, 5'd31);
		send_item(FUNC_COUNT, 6'd0, 6'd0, 5'd0);
		write_states(7'd0);
		send_item(FUNC_COUNT, 6'd0, 6'd0, 5'd0);

		// Register saturated to the largest size, with a sparse automaton.
		write_states(7'd127);
		send_item(FUNC_CLEAR, 6'd0, 6'd0, 5'd0);
		send_item(FUNC_SET_EDGE, 6'd0, 6'd63, 5'd0);
		send_item(FUNC_SET_EDGE, 6'd0, 6'd63, 5'd1);
		send_item(FUNC_MARK, 6'd63, 6'd0, 5'd0);
		send_item(FUNC_COUNT, 6'd0, 6'd0, 5'd0);

		// Target and source beyond the states in use.
		write_states(7'd5);
		send_item(FUNC_SET_EDGE, 6'd63, 6'd0, 5'd2);
		send_item(FUNC_COUNT, 6'd0, 6'd0, 5'd0);

		// Long receiver hold-off while counts pile up behind the result.
		write_states(7'd2);
		send_item(FUNC_CLEAR, 6'd0, 6'd0, 5'd0);
		send_item(FUNC_SET_EDGE, 6'd0, 6'd1, 5'd0);
		send_item(FUNC_MARK, 6'd1, 6'd0, 5'd0);
		recv_hold = 20000;
		send_item(FUNC_COUNT, 6'd0, 6'd0, 5'd0);
		send_item(FUNC_COUNT, 6'd0, 6'd0, 5'd0);
		send_item(FUNC_COUNT, 6'd0, 6'd0, 5'd0);
		write_states(7'd64);
		send_item(FUNC_COUNT, 6'd0, 6'd0, 5'd0);

		// Random sequences under three idling regimes.
		for (int g = 0; g < 30; g++) begin
			if (g == 0) begin
				send_idle_pct = 14;
				recv_idle_pct = 63;
			end else if (g == 10) begin
				send_idle_pct = 63;
				recv_idle_pct = 14;
			end else if (g == 20) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			if (g % 5 == 0) write_states(7'($urandom_range(1, 8)));
			random_group();
		end

		drain();
		$display("Covered %0d count results, %0d of them infinite, over register values 0 to 127.",
			board.results_seen, board.infinite_seen);
		if (board.errors == 0 && board.pending_q.size() == 0) begin
			$display("dfa_word_counter_unit regression: pass");
		end else begin
			$display("dfa_word_counter_unit regression: fail");
		end
		$finish;
	end

endmodule
